// ===== rtl/core/modbus_rtu_slave_register_bank_assert.svh =====
// assertion macros for the register bank checker
`ifndef MODBUS_RTU_SLAVE_REGISTER_BANK_ASSERT_SVH
`define MODBUS_RTU_SLAVE_REGISTER_BANK_ASSERT_SVH
// implication checked every edge outside reset
`define MRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/mrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrb_pkg
// shared types and constants of the modbus register bank
// ----------------------------------------------------------------------------
package mrb_pkg;
    localparam int GroupDepth  = 64;
    localparam int NumGroups   = 3;
    localparam int MaxReadRegs = 16;
    localparam int StoreDepth  = NumGroups * GroupDepth;
    localparam int IdxW        = $clog2(StoreDepth);
    localparam int OffW        = $clog2(GroupDepth);

    localparam logic [1:0] CMD_HEADER = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    localparam logic [7:0] FC_READ_HOLD  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT = 8'd4;
    localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
    localparam logic [7:0] FC_WRITE_MULT = 8'd16;

    localparam logic [2:0] REG_SLAVE_ID   = 3'd0;
    localparam logic [2:0] REG_HOLD_WIN0  = 3'd1;
    localparam logic [2:0] REG_HOLD_WIN1  = 3'd2;
    localparam logic [2:0] REG_HOLD_WIN2  = 3'd3;
    localparam logic [2:0] REG_INPUT_WIN0 = 3'd4;
    localparam logic [2:0] REG_INPUT_WIN1 = 3'd5;
    localparam logic [2:0] REG_INPUT_WIN2 = 3'd6;

    // job kinds handed from front to back
    typedef enum logic [2:0] {
        JOB_LOAD,
        JOB_HWRITE,
        JOB_READ,
        JOB_ECHO,
        JOB_BCAST
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic             hold;
        logic [IdxW-1:0]  idx;
        logic [15:0]      value;
        logic [7:0]       code;
        logic [15:0]      addr;
        logic [15:0]      count;
        logic [7:0]       sid;
        logic             upd;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD,
        BK_SEND,
        BK_CRCL,
        BK_CRCH
    } bk_state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction
endpackage

// ===== rtl/core/mrb_ram.sv =====
// ----------------------------------------------------------------------------
// mrb_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module mrb_ram #(
    parameter int Width = 16,
    parameter int Depth = 192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/mrb_front.sv =====
// ----------------------------------------------------------------------------
// mrb_front
// accepts items, checks windows, tracks write-multiple progress, emits jobs
// ----------------------------------------------------------------------------
module mrb_front import mrb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  slave_address,
    input  logic [7:0]  function_code,
    input  logic [15:0] reg_address,
    input  logic [15:0] count_or_value,
    input  logic [15:0] data_word,
    input  logic [7:0]  local_index,
    input  logic [7:0]  slave_id,
    input  logic [31:0] hwin [3],
    input  logic [31:0] iwin [3],
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    logic        pact_reg, pact_next, pdis_reg, pdis_next, pbc_reg, pbc_next;
    logic [1:0]  pgrp_reg, pgrp_next;
    logic [15:0] poff_reg, poff_next, prem_reg, prem_next;
    logic [15:0] paddr_reg, paddr_next, pcnt_reg, pcnt_next;

    logic        hold_sel, hit;
    logic [1:0]  grp;
    logic [15:0] base, off, len;
    logic        addressed, bc;
    logic [31:0] w;
    logic [16:0] wl;
    job_t        j;
    logic        jv;

    assign len = (function_code == FC_WRITE_ONE) ? 16'd1 : count_or_value;
    assign hold_sel = (function_code != FC_READ_INPUT);

    // lowest-numbered fitting window wins; searched from the highest down
    always_comb begin
        hit = 1'b0;
        grp = 2'd0;
        base = 16'd0;
        for (int g = NumGroups - 1; g >= 0; g--) begin
            w = hold_sel ? hwin[g] : iwin[g];
            wl = (w[15:0] > 16'(GroupDepth)) ? 17'(GroupDepth) : {1'b0, w[15:0]};
            if (w[15:0] != 16'd0 && reg_address >= w[31:16] &&
                ({1'b0, reg_address} + {1'b0, len} <= {1'b0, w[31:16]} + wl)) begin
                hit = 1'b1;
                grp = 2'(g);
                base = w[31:16];
            end
        end
    end
    assign off = reg_address - base;
    assign bc = (slave_address == 8'd0);
    assign addressed = bc || (slave_address == slave_id);

    always_comb begin
        pact_next = pact_reg; pdis_next = pdis_reg; pbc_next = pbc_reg;
        pgrp_next = pgrp_reg; poff_next = poff_reg; prem_next = prem_reg;
        paddr_next = paddr_reg; pcnt_next = pcnt_reg;
        jv = 1'b0;
        j = '0;
        j.kind = JOB_LOAD;
        j.sid = slave_id;
        j.code = function_code;
        j.addr = reg_address;
        j.count = count_or_value;
        j.hold = hold_sel;
        j.value = data_word;
        j.idx = IdxW'({8'd0, grp} * GroupDepth + {8'd0, off[OffW-1:0]});
        unique case (command)
            CMD_LOAD: begin
                j.kind = JOB_LOAD;
                j.idx = local_index[IdxW-1:0];
                jv = ({24'd0, local_index} < 32'(StoreDepth));
            end
            CMD_DATA: begin
                if (pact_reg) begin
                    poff_next = poff_reg + 16'd1;
                    prem_next = prem_reg - 16'd1;
                    j.kind = JOB_HWRITE;
                    j.idx = IdxW'({14'd0, pgrp_reg} * GroupDepth
                                  + {10'd0, poff_reg[OffW-1:0]});
                    jv = !pdis_reg && (poff_reg < 16'(GroupDepth));
                    j.code = FC_WRITE_MULT;
                    j.addr = paddr_reg;
                    j.count = pcnt_reg;
                    j.upd = (prem_reg == 16'd1) && !pdis_reg;
                    j.value = data_word;
                    if (prem_reg == 16'd1) begin
                        pact_next = 1'b0;
                        j.kind = pbc_reg ? JOB_BCAST : JOB_ECHO;
                        // last word writes and then responds
                        j.hold = 1'b1;
                        jv = !pdis_reg;
                    end
                end
            end
            CMD_HEADER: begin
                pact_next = 1'b0;
                pdis_next = 1'b0;
                if (function_code == FC_WRITE_MULT) begin
                    if (count_or_value != 16'd0) begin
                        pact_next = 1'b1;
                        pdis_next = !(addressed && hit);
                        prem_next = count_or_value;
                        pgrp_next = (addressed && hit) ? grp : 2'd0;
                        poff_next = (addressed && hit) ? off : 16'd0;
                        paddr_next = reg_address;
                        pcnt_next = count_or_value;
                        pbc_next = bc;
                    end
                end else if (addressed && hit) begin
                    if ((function_code == FC_READ_HOLD || function_code == FC_READ_INPUT)
                        && !bc && count_or_value != 16'd0
                        && count_or_value <= 16'(MaxReadRegs)) begin
                        j.kind = JOB_READ;
                        jv = 1'b1;
                    end else if (function_code == FC_WRITE_ONE) begin
                        j.kind = bc ? JOB_BCAST : JOB_ECHO;
                        j.value = count_or_value;
                        j.count = 16'd1;
                        j.upd = 1'b1;
                        jv = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign in_ready = job_ready;
    assign job_valid = in_valid && jv;
    assign job = j;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pact_reg <= 1'b0; pdis_reg <= 1'b0; pbc_reg <= 1'b0;
            pgrp_reg <= '0; poff_reg <= '0; prem_reg <= '0;
            paddr_reg <= '0; pcnt_reg <= '0;
        end else if (in_valid && in_ready) begin
            pact_reg <= pact_next; pdis_reg <= pdis_next; pbc_reg <= pbc_next;
            pgrp_reg <= pgrp_next; poff_reg <= poff_next; prem_reg <= prem_next;
            paddr_reg <= paddr_next; pcnt_reg <= pcnt_next;
        end
    end
endmodule

// ===== rtl/core/mrb_queue.sv =====
// ----------------------------------------------------------------------------
// mrb_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module mrb_queue import mrb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);
    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_job;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/core/mrb_back.sv =====
// ----------------------------------------------------------------------------
// mrb_back
// executes jobs on the stores and serializes response bytes with crc
// ----------------------------------------------------------------------------
module mrb_back import mrb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    bk_state_t   st_reg, st_next;
    job_t        j_reg, j_next;
    logic [15:0] crc_reg, crc_next;
    logic [5:0]  pos_reg, pos_next;
    logic [IdxW-1:0] ra_reg, ra_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        ov_reg, ov_next, ol_reg, ol_next;
    logic        obv_reg, obv_next;
    logic [7:0]  ob_reg, ob_next;
    logic [5:0]  nbytes;
    logic [7:0]  cur;

    // store side: clear sweep, then written through ram ports
    logic [IdxW:0]   clr_reg;
    logic            clearing;
    logic            h_we, i_we;
    logic [IdxW-1:0] h_a, i_a;
    logic [15:0]     h_wd, i_wd, h_rd, i_rd, rd;

    assign clearing = (clr_reg != (IdxW+1)'(StoreDepth));

    mrb_ram #(.Width(16), .Depth(StoreDepth)) u_hold (
        .aclk(aclk), .we(h_we), .addr(h_a), .wdata(h_wd), .rdata(h_rd));
    mrb_ram #(.Width(16), .Depth(StoreDepth)) u_inp (
        .aclk(aclk), .we(i_we), .addr(i_a), .wdata(i_wd), .rdata(i_rd));

    assign rd = j_reg.hold ? h_rd : i_rd;
    assign nbytes = 6'd3 + {j_reg.count[4:0], 1'b0};

    always_comb begin
        st_next = st_reg; j_next = j_reg; crc_next = crc_reg; pos_next = pos_reg;
        ra_next = ra_reg; hold_byte_next = hold_byte_reg;
        ov_next = ov_reg; ol_next = ol_reg; obv_next = obv_reg; ob_next = ob_reg;
        job_ready = 1'b0;
        // a stalled read keeps its address so the read word stays put
        h_we = clearing; h_a = clearing ? clr_reg[IdxW-1:0] : ra_reg; h_wd = '0;
        i_we = clearing; i_a = clearing ? clr_reg[IdxW-1:0] : ra_reg; i_wd = '0;
        cur = 8'd0;
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (st_reg)
            BK_IDLE: begin
                job_ready = !clearing && !(ov_reg && !m_tready);
                if (job_valid && job_ready) begin
                    j_next = job;
                    crc_next = 16'hFFFF;
                    pos_next = '0;
                    ra_next = job.idx;
                    unique case (job.kind)
                        JOB_LOAD: begin
                            i_we = 1'b1; i_a = job.idx; i_wd = job.value;
                        end
                        JOB_HWRITE: begin
                            h_we = 1'b1; h_a = job.idx; h_wd = job.value;
                        end
                        JOB_READ: begin
                            h_a = job.idx; i_a = job.idx;
                            st_next = BK_SEND;
                        end
                        JOB_ECHO, JOB_BCAST: begin
                            // single writes and the final write-multiple word
                            h_we = job.upd;
                            h_a = job.idx; h_wd = job.value;
                            if (job.kind == JOB_BCAST) begin
                                ov_next = 1'b1; obv_next = 1'b0; ob_next = 8'd0;
                                ol_next = 1'b1;
                            end else begin
                                st_next = BK_SEND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_SEND: begin
                if (!ov_reg || m_tready) begin
                    if (j_reg.kind == JOB_READ) begin
                        if (pos_reg == 6'd0) cur = j_reg.sid;
                        else if (pos_reg == 6'd1) cur = j_reg.code;
                        else if (pos_reg == 6'd2) cur = {j_reg.count[6:0], 1'b0};
                        else if (pos_reg[0]) cur = rd[15:8];
                        else cur = hold_byte_reg;
                        if (pos_reg >= 6'd3 && pos_reg[0]) begin
                            hold_byte_next = rd[7:0];
                            ra_next = ra_reg + 1'b1;
                            h_a = ra_reg + 1'b1; i_a = ra_reg + 1'b1;
                        end else begin
                            h_a = ra_reg; i_a = ra_reg;
                        end
                    end else begin
                        unique case (pos_reg[2:0])
                            3'd0: cur = j_reg.sid;
                            3'd1: cur = j_reg.code;
                            3'd2: cur = j_reg.addr[15:8];
                            3'd3: cur = j_reg.addr[7:0];
                            3'd4: cur = (j_reg.code == FC_WRITE_ONE) ?
                                        j_reg.value[15:8] : j_reg.count[15:8];
                            default: cur = (j_reg.code == FC_WRITE_ONE) ?
                                        j_reg.value[7:0] : j_reg.count[7:0];
                        endcase
                    end
                    ov_next = 1'b1; obv_next = 1'b1; ob_next = cur; ol_next = 1'b0;
                    crc_next = crc_byte(crc_reg, cur);
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == ((j_reg.kind == JOB_READ) ? nbytes - 6'd1 : 6'd5))
                        st_next = BK_CRCL;
                end
            end
            BK_CRCL: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1; obv_next = 1'b1; ob_next = crc_reg[7:0];
                    ol_next = 1'b0; st_next = BK_CRCH;
                end
            end
            BK_CRCH: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1; obv_next = 1'b1; ob_next = crc_reg[15:8];
                    ol_next = 1'b1; st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next; crc_reg <= crc_next; pos_reg <= pos_next;
        ra_reg <= ra_next; hold_byte_reg <= hold_byte_next;
        obv_reg <= obv_next; ob_reg <= ob_next; ol_reg <= ol_next;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BK_IDLE; ov_reg <= 1'b0; clr_reg <= '0;
        end else begin
            st_reg <= st_next; ov_reg <= ov_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast = ol_reg;
    assign m_tdata = {6'd0,
                      j_reg.upd ? j_reg.count : 16'd0,
                      j_reg.upd ? j_reg.addr : 16'd0,
                      j_reg.upd, ob_reg, obv_reg};
endmodule

// ===== rtl/core/modbus_rtu_slave_register_bank.sv =====
// one response at a time; a new job is taken only once the serializer is idle
// accepts items into a two-entry queue while a response is still going out
// after reset the stores are swept to zero; items queue up meanwhile
// reset clears control state, slave_id to 1 and windows to 0
module modbus_rtu_slave_register_bank import mrb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command, slave_address, function_code, reg_address, count_or_value,
    // data_word, local_index
    input  logic [79:0] s_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_valid, tx_byte, update_flag, update_addr, update_count
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    logic [7:0]  sid_reg;
    logic [31:0] hwin_reg [3];
    logic [31:0] iwin_reg [3];
    logic [47:0] raw;
    logic        fv, fr, qv, qr;
    job_t        fj, qj;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sid_reg <= 8'd1;
            for (int i = 0; i < 3; i++) begin
                hwin_reg[i] <= '0; iwin_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_SLAVE_ID) sid_reg <= cfg_data[7:0];
            else if (cfg_index <= REG_HOLD_WIN2)
                hwin_reg[2'(cfg_index - REG_HOLD_WIN0)] <= cfg_data;
            else if (cfg_index <= REG_INPUT_WIN2)
                iwin_reg[2'(cfg_index - REG_INPUT_WIN0)] <= cfg_data;
        end
    end

    mrb_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .command(s_tdata[1:0]), .slave_address(s_tdata[9:2]),
        .function_code(s_tdata[17:10]), .reg_address(s_tdata[33:18]),
        .count_or_value(s_tdata[49:34]), .data_word(s_tdata[65:50]),
        .local_index(s_tdata[73:66]), .slave_id(sid_reg),
        .hwin(hwin_reg), .iwin(iwin_reg),
        .job_valid(fv), .job_ready(fr), .job(fj));

    mrb_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(fv), .in_ready(fr), .in_job(fj),
        .out_valid(qv), .out_ready(qr), .out_job(qj));

    mrb_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(qv), .job_ready(qr), .job(qj),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(raw), .m_tlast(m_tlast));

    // byte_valid 0 forces tx_byte to 0
    assign m_tdata = {raw[47:9], raw[0] ? raw[8:1] : 8'd0, raw[0]};
endmodule

// ===== rtl/core/mrb_checker.sv =====
// ----------------------------------------------------------------------------
// mrb_checker
// port-level checks on the register bank
// ----------------------------------------------------------------------------
`include "modbus_rtu_slave_register_bank_assert.svh"
module mrb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_ready
);
    `MRB_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MRB_ASSERT_IMP(a_nobyte_last, aclk, aresetn, m_tvalid && !m_tdata[0], m_tlast)
    `MRB_ASSERT_IMP(a_upd_zero, aclk, aresetn, m_tvalid && !m_tdata[9], m_tdata[47:10] == '0)
    `MRB_ASSERT_IMP(a_cfg, aclk, aresetn, 1'b1, cfg_ready)
endmodule

bind modbus_rtu_slave_register_bank mrb_checker u_mrb_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .cfg_ready(cfg_ready));
